/* rtl/dtbl_pkg.sv */
// dual token bucket limiter: shared types and constants
// fsm states, controller command and status structs, outcome and register codes
// no dependencies
package dtbl_pkg;

  // fixed point and field widths
  localparam int FRAC_BITS   = 8;
  localparam int BURST_OPS_W = 20;
  localparam int BURST_BYT_W = 32;
  localparam int OPS_W       = BURST_OPS_W + FRAC_BITS;  // operation bucket level
  localparam int BYT_W       = BURST_BYT_W + FRAC_BITS;  // byte bucket level
  localparam int REQ_BYTES_W = 32;
  localparam int TAG_W       = 16;
  localparam int OUTCOME_W   = 3;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 40;
  localparam int ENTRY_W     = TAG_W + REQ_BYTES_W;

  // most results one tick may produce
  localparam int MAX_RESULTS = 16;
  localparam int REL_CNT_W   = $clog2(MAX_RESULTS + 1);

  // one whole operation token
  localparam logic [OPS_W-1:0] ONE_OP = OPS_W'(1) << FRAC_BITS;

  typedef enum logic [OUTCOME_W-1:0] {
    OC_PASS      = 3'd0,
    OC_QUEUED    = 3'd1,
    OC_DROPPED   = 3'd2,
    OC_RELEASED  = 3'd3,
    OC_TICK_NONE = 3'd4
  } outcome_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ENABLE       = 3'd0,
    REG_BURST_OPS    = 3'd1,
    REG_BYTE_BURST   = 3'd2,
    REG_REFILL_OPS   = 3'd3,
    REG_REFILL_BYTES = 3'd4
  } reg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_TEST,
    S_SETTLE,
    S_RELOUT,
    S_OUT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load_item;   // capture the input request
    logic do_request;  // decide a request and load its result
    logic do_refill;   // add per-tick refill, capped at burst
    logic do_release;  // pop head into hold, push earlier hold out
    logic do_close;    // final result of a tick
  } ctl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_tick;
    logic enabled;
    logic rel_ok;      // head entry may be released now
    logic hold_valid;  // a released entry waits in hold
    logic out_taken;   // result accepted this cycle
  } ctl_status_t;

endpackage

/* rtl/dtbl_ctrl.sv */
// dual token bucket limiter: sequencing state machine
// drives datapath commands from request and tick flow, depends on dtbl_pkg
module dtbl_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  dtbl_pkg::ctl_status_t status,
  output dtbl_pkg::ctl_cmd_t    cmd
);
  import dtbl_pkg::*;

  state_t state;
  state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_EVAL;
      end
      S_EVAL: begin
        if (status.is_tick && status.enabled) state_next = S_TEST;
        else state_next = S_OUT;
      end
      S_TEST: begin
        if (!status.rel_ok) state_next = S_OUT;
        else if (status.hold_valid) state_next = S_RELOUT;
        else state_next = S_SETTLE;
      end
      S_SETTLE: begin
        state_next = S_TEST;
      end
      S_RELOUT: begin
        if (status.out_taken) state_next = S_TEST;
      end
      S_OUT: begin
        if (status.out_taken) begin
          if (in_valid) state_next = S_EVAL;
          else state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready = 1'b0;
    cmd      = '0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
      end
      S_EVAL: begin
        if (!status.is_tick) cmd.do_request = 1'b1;
        else if (status.enabled) cmd.do_refill = 1'b1;
        else cmd.do_close = 1'b1;
      end
      S_TEST: begin
        if (status.rel_ok) cmd.do_release = 1'b1;
        else cmd.do_close = 1'b1;
      end
      S_OUT: begin
        in_ready = status.out_taken;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
    cmd.load_item = in_valid && in_ready;
  end

endmodule

/* rtl/dtbl_datapath.sv */
// dual token bucket limiter: buckets, wait queue memory, result register
// acts on dtbl_ctrl commands, depends on dtbl_pkg
module dtbl_datapath #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  // configuration
  input  logic                              cfg_we,
  input  logic [dtbl_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [dtbl_pkg::CFG_DATA_W-1:0]   cfg_data,
  // input request fields
  input  logic                              opcode,
  input  logic [dtbl_pkg::REQ_BYTES_W-1:0]  req_bytes,
  input  logic [dtbl_pkg::TAG_W-1:0]        req_tag,
  // controller link
  input  dtbl_pkg::ctl_cmd_t                cmd,
  output dtbl_pkg::ctl_status_t             status,
  // result channel
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [dtbl_pkg::OUTCOME_W-1:0]    outcome,
  output logic [dtbl_pkg::TAG_W-1:0]        out_tag,
  output logic [dtbl_pkg::REQ_BYTES_W-1:0]  out_bytes,
  output logic                              last
);
  import dtbl_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(QUEUE_DEPTH);

  // configuration registers
  logic                   enable;
  logic [BURST_OPS_W-1:0] burst_ops;
  logic [BURST_BYT_W-1:0] byte_burst;
  logic [OPS_W-1:0]       refill_ops;
  logic [BYT_W-1:0]       refill_bytes;

  // bucket levels
  logic [OPS_W-1:0] ops_level;
  logic [BYT_W-1:0] byte_level;

  // wait queue
  logic [ENTRY_W-1:0] queue_mem [QUEUE_DEPTH];
  logic [ENTRY_W-1:0] head_data;
  logic [PTR_W-1:0]   head_ptr;
  logic [PTR_W-1:0]   tail_ptr;
  logic [CNT_W-1:0]   wait_count;

  // current item and release bookkeeping
  logic                   item_tick;
  logic [REQ_BYTES_W-1:0] item_bytes;
  logic [TAG_W-1:0]       item_tag;
  logic [REL_CNT_W-1:0]   rel_cnt;
  logic                   hold_valid;
  logic [REQ_BYTES_W-1:0] hold_bytes;
  logic [TAG_W-1:0]       hold_tag;

  // combinational helpers
  logic [OPS_W-1:0]       cap_ops;
  logic [BYT_W-1:0]       cap_bytes;
  logic [OPS_W:0]         ops_sum;
  logic [BYT_W:0]         byte_sum;
  logic [TAG_W-1:0]       head_tag;
  logic [REQ_BYTES_W-1:0] head_bytes;
  logic [BYT_W-1:0]       item_debit;
  logic [BYT_W-1:0]       head_debit;
  logic                   ops_ok;
  logic                   item_ok;
  logic                   head_ok;
  logic                   queue_full;
  logic                   emit;

  assign cap_ops    = {burst_ops, FRAC_BITS'(0)};
  assign cap_bytes  = {byte_burst, FRAC_BITS'(0)};
  assign ops_sum    = {1'b0, ops_level} + {1'b0, refill_ops};
  assign byte_sum   = {1'b0, byte_level} + {1'b0, refill_bytes};
  assign head_tag   = head_data[ENTRY_W-1 -: TAG_W];
  assign head_bytes = head_data[REQ_BYTES_W-1:0];
  assign item_debit = {item_bytes, FRAC_BITS'(0)};
  assign head_debit = {head_bytes, FRAC_BITS'(0)};
  assign ops_ok     = ops_level >= ONE_OP;
  assign item_ok    = ops_ok && (byte_level >= item_debit);
  assign head_ok    = ops_ok && (byte_level >= head_debit);
  assign queue_full = wait_count == FULL_CNT;
  assign emit       = cmd.do_request || cmd.do_close || (cmd.do_release && hold_valid);

  // status to controller
  always_comb begin
    status.is_tick    = item_tick;
    status.enabled    = enable;
    status.rel_ok     = (wait_count != '0) && (rel_cnt < REL_CNT_W'(MAX_RESULTS)) && head_ok;
    status.hold_valid = hold_valid;
    status.out_taken  = out_valid && out_ready;
  end

  // configuration registers and bucket levels
  always_ff @(posedge clk) begin
    if (rst) begin
      enable       <= 1'b0;
      burst_ops    <= '0;
      byte_burst   <= '0;
      refill_ops   <= '0;
      refill_bytes <= '0;
      ops_level    <= '0;
      byte_level   <= '0;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_ENABLE: begin
          enable <= cfg_data[0];
        end
        REG_BURST_OPS: begin
          burst_ops <= cfg_data[BURST_OPS_W-1:0];
          ops_level <= {cfg_data[BURST_OPS_W-1:0], FRAC_BITS'(0)};
        end
        REG_BYTE_BURST: begin
          byte_burst <= cfg_data[BURST_BYT_W-1:0];
          byte_level <= {cfg_data[BURST_BYT_W-1:0], FRAC_BITS'(0)};
        end
        REG_REFILL_OPS: begin
          refill_ops <= cfg_data[OPS_W-1:0];
        end
        REG_REFILL_BYTES: begin
          refill_bytes <= cfg_data[BYT_W-1:0];
        end
        default: begin
          enable <= enable;
        end
      endcase
    end else if (cmd.do_request) begin
      // pass at once when both buckets suffice
      if (enable && item_ok) begin
        ops_level  <= ops_level - ONE_OP;
        byte_level <= byte_level - item_debit;
      end
    end else if (cmd.do_refill) begin
      ops_level  <= (ops_sum > {1'b0, cap_ops}) ? cap_ops : ops_sum[OPS_W-1:0];
      byte_level <= (byte_sum > {1'b0, cap_bytes}) ? cap_bytes : byte_sum[BYT_W-1:0];
    end else if (cmd.do_release) begin
      ops_level  <= ops_level - ONE_OP;
      byte_level <= byte_level - head_debit;
    end
  end

  // queue memory, head entry read registered every cycle
  always_ff @(posedge clk) begin
    if (cmd.do_request && enable && !item_ok && !queue_full) begin
      queue_mem[tail_ptr] <= {item_tag, item_bytes};
    end
    head_data <= queue_mem[head_ptr];
  end

  // queue pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      head_ptr   <= '0;
      tail_ptr   <= '0;
      wait_count <= '0;
    end else if (cmd.do_request && enable && !item_ok && !queue_full) begin
      tail_ptr   <= (tail_ptr == LAST_SLOT) ? '0 : tail_ptr + 1'b1;
      wait_count <= wait_count + 1'b1;
    end else if (cmd.do_release) begin
      head_ptr   <= (head_ptr == LAST_SLOT) ? '0 : head_ptr + 1'b1;
      wait_count <= wait_count - 1'b1;
    end
  end

  // captured item
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item_tick  <= opcode;
      item_bytes <= req_bytes;
      item_tag   <= req_tag;
    end
  end

  // release count and hold stage
  always_ff @(posedge clk) begin
    if (rst) begin
      rel_cnt    <= '0;
      hold_valid <= 1'b0;
    end else if (cmd.load_item) begin
      rel_cnt    <= '0;
      hold_valid <= 1'b0;
    end else if (cmd.do_release) begin
      rel_cnt    <= rel_cnt + 1'b1;
      hold_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.do_release) begin
      hold_tag   <= head_tag;
      hold_bytes <= head_bytes;
    end
  end

  // result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (cmd.do_request) begin
      out_tag   <= item_tag;
      out_bytes <= item_bytes;
      last      <= 1'b1;
      if (!enable || item_ok) outcome <= OC_PASS;
      else if (!queue_full) outcome <= OC_QUEUED;
      else outcome <= OC_DROPPED;
    end else if (cmd.do_release && hold_valid) begin
      // earlier release goes out, another follows
      outcome   <= OC_RELEASED;
      out_tag   <= hold_tag;
      out_bytes <= hold_bytes;
      last      <= 1'b0;
    end else if (cmd.do_close) begin
      last <= 1'b1;
      if (hold_valid) begin
        outcome   <= OC_RELEASED;
        out_tag   <= hold_tag;
        out_bytes <= hold_bytes;
      end else begin
        outcome   <= OC_TICK_NONE;
        out_tag   <= '0;
        out_bytes <= '0;
      end
    end
  end

endmodule

/* rtl/dual_token_bucket_limiter.sv */
// dual token bucket limiter: top level
// joins dtbl_ctrl and dtbl_datapath, depends on dtbl_pkg
//
//   channel  signals                                  direction
//   in       in_valid in_ready opcode req_bytes req_tag  request in
//   out      out_valid out_ready outcome out_tag out_bytes last  result out
//   cfg      cfg_valid cfg_ready cfg_index cfg_data   register write in
//
// a request or a disabled tick goes through a decision, then the result register.
// an enabled tick runs the refill, then per released entry a release decision
// and the registered read of the next queue head, a final test, then the
// result register.
// reset is synchronous; the queue memory is not cleared, only its pointers.
// out_ready low holds the result register and the sequence; cfg is always ready.
module dual_token_bucket_limiter #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              opcode,
  input  logic [dtbl_pkg::REQ_BYTES_W-1:0]  req_bytes,
  input  logic [dtbl_pkg::TAG_W-1:0]        req_tag,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [dtbl_pkg::OUTCOME_W-1:0]    outcome,
  output logic [dtbl_pkg::TAG_W-1:0]        out_tag,
  output logic [dtbl_pkg::REQ_BYTES_W-1:0]  out_bytes,
  output logic                              last,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [dtbl_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [dtbl_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import dtbl_pkg::*;

  ctl_cmd_t    cmd;
  ctl_status_t status;

  // register writes are taken at once
  assign cfg_ready = 1'b1;

  dtbl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  dtbl_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .opcode    (opcode),
    .req_bytes (req_bytes),
    .req_tag   (req_tag),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .outcome   (outcome),
    .out_tag   (out_tag),
    .out_bytes (out_bytes),
    .last      (last)
  );

endmodule
